### hdl/assert_macros.svh
// Assertion helper macros for the percent codec RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/upc_pkg.sv
// Shared types, codes and character helpers for the percent codec.
// No dependencies.
package upc_pkg;

    // Escape tracking while decoding.
    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_HIGH = 3'b010,
        ESC_LOW  = 3'b100
    } esc_t;

    // Configuration register indexes.
    localparam logic REG_DIRECTION    = 1'b0;
    localparam logic REG_OUT_CAPACITY = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    typedef struct packed {
        esc_t       esc;
        logic [3:0] hi;
        logic       err;
    } codec_state_t;

    // Results caused by one input word: data bytes first, then the end result.
    typedef struct packed {
        logic [1:0]      data_cnt;
        logic            has_end;
        logic            failed;
        logic [15:0]     count;
        logic [2:0][7:0] bytes;
    } bundle_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hexval_t;

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
               (c >= 8'h41 && c <= 8'h5a) || c == 8'h2d || c == 8'h2e ||
               c == 8'h5f || c == 8'h7e;
    endfunction

    function automatic hexval_t hex_value(input logic [7:0] c);
        hexval_t r;
        r.ok  = 1'b1;
        r.val = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.val = 4'(c - 8'h37);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Upper-case hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

endpackage

### hdl/url_percent_codec_core.sv
// Top level of the percent codec: config registers, string state, per-word
// logic and result register. Depends on upc_pkg, upc_step, upc_out.
//
//  channel | direction | signals                                  | handshake
//  s_      | in        | s_in_byte, s_in_last                     | s_valid/s_ready
//  m_      | out       | m_out_byte, m_is_data, m_is_end,         | m_valid/m_ready
//          |           | m_failed, m_out_count, m_run_last        |
//  cfg_    | in        | cfg_index, cfg_wdata                     | cfg_we
//
// A word is taken every cycle while it causes at most one result and m_ready is high; a word
// with n results (up to four: three encoded bytes plus the end) holds the single result
// register until all n are handed out, one result per cycle while m_ready is high.
// Reset clears the string state and config to direction encode, capacity 65535.
// Input is taken while the last pending result is being handed out.
`include "assert_macros.svh"

module url_percent_codec_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_is_data,
    output logic        m_is_end,
    output logic        m_failed,
    output logic [15:0] m_out_count,
    output logic        m_run_last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    logic                   direction_reg;
    logic [15:0]            capacity_reg;
    upc_pkg::codec_state_t  st_reg, st_next;
    logic [COUNT_WIDTH-1:0] produced_reg, produced_next;
    upc_pkg::bundle_t       bundle;
    logic                   has_result;
    logic                   free;
    logic                   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= upc_pkg::DIR_ENCODE;
            capacity_reg  <= 16'hffff;
        end else if (cfg_we) begin
            unique case (cfg_index)
                upc_pkg::REG_DIRECTION:    direction_reg <= cfg_wdata[0];
                upc_pkg::REG_OUT_CAPACITY: capacity_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    upc_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .direction     (direction_reg),
        .out_capacity  (capacity_reg),
        .st            (st_reg),
        .produced      (produced_reg),
        .in_byte       (s_in_byte),
        .in_last       (s_in_last),
        .st_next       (st_next),
        .produced_next (produced_next),
        .bundle        (bundle),
        .has_result    (has_result)
    );

    assign s_ready = free;
    assign accept  = s_valid && free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.esc   <= upc_pkg::ESC_NONE;
            st_reg.hi    <= 4'h0;
            st_reg.err   <= 1'b0;
            produced_reg <= '0;
        end else if (accept) begin
            st_reg       <= st_next;
            produced_reg <= produced_next;
        end
    end

    upc_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept && has_result),
        .bundle      (bundle),
        .free        (free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_is_data   (m_is_data),
        .m_is_end    (m_is_end),
        .m_failed    (m_failed),
        .m_out_count (m_out_count),
        .m_run_last  (m_run_last)
    );

    `ASSERT_NEXT(a_last_clears, accept && s_in_last,
                 st_reg.esc == upc_pkg::ESC_NONE && !st_reg.err && produced_reg == '0,
                 "string state not cleared after last word")
    `ASSERT_NEXT(a_err_sticks, accept && st_reg.err && !s_in_last,
                 st_reg.err && $stable(produced_reg), "error state lost mid string")
    `ASSERT_IMPL(a_ready_when_idle, !m_valid, s_ready, "input stalled with no result pending")

endmodule

### hdl/upc_step.sv
// Per-word codec logic: next string state and the results of one input word.
// Depends on upc_pkg.
module upc_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      direction,
    input  logic [15:0]               out_capacity,
    input  upc_pkg::codec_state_t     st,
    input  logic [COUNT_WIDTH-1:0]    produced,
    input  logic [7:0]                in_byte,
    input  logic                      in_last,
    output upc_pkg::codec_state_t     st_next,
    output logic [COUNT_WIDTH-1:0]    produced_next,
    output upc_pkg::bundle_t          bundle,
    output logic                      has_result
);
    localparam int SW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [SW-1:0]  cap_ext;
    logic [SW-1:0]  lim_ext;
    logic [SW-1:0]  cap;
    logic [SW-1:0]  prod_ext;
    logic [SW-1:0]  prod_sum;
    logic           room1;
    logic           room3;
    logic           unres;
    upc_pkg::hexval_t hv;
    upc_pkg::codec_state_t s;
    logic [1:0]     nd;
    logic [2:0][7:0] b;

    always_comb begin
        cap_ext  = SW'(out_capacity);
        lim_ext  = SW'(CNT_MAX);
        cap      = (cap_ext < lim_ext) ? cap_ext : lim_ext;
        prod_ext = SW'(produced);
        room1    = (prod_ext + SW'(1)) <= cap;
        room3    = (prod_ext + SW'(3)) <= cap;
        unres    = upc_pkg::is_unreserved(in_byte);
        hv       = upc_pkg::hex_value(in_byte);
    end

    always_comb begin
        s  = st;
        nd = 2'd0;
        b  = '0;
        if (!st.err) begin
            if (direction == upc_pkg::DIR_ENCODE) begin
                // escape state is left alone while encoding
                if (unres) begin
                    if (room1) begin
                        b[0] = in_byte;
                        nd   = 2'd1;
                    end else begin
                        s.err = 1'b1;
                    end
                end else if (room3) begin
                    b[0] = upc_pkg::CHAR_PERCENT;
                    b[1] = upc_pkg::hex_digit(in_byte[7:4]);
                    b[2] = upc_pkg::hex_digit(in_byte[3:0]);
                    nd   = 2'd3;
                end else begin
                    s.err = 1'b1;
                end
            end else begin
                unique case (st.esc)
                    upc_pkg::ESC_HIGH, upc_pkg::ESC_LOW: begin
                        if (!hv.ok) begin
                            s.err = 1'b1;
                        end else if (st.esc == upc_pkg::ESC_HIGH) begin
                            s.hi  = hv.val;
                            s.esc = upc_pkg::ESC_LOW;
                        end else begin
                            b[0]  = {st.hi, hv.val};
                            nd    = 2'd1;
                            s.esc = upc_pkg::ESC_NONE;
                        end
                    end
                    default: begin
                        s.esc = upc_pkg::ESC_NONE;
                        if (in_byte == upc_pkg::CHAR_PERCENT) begin
                            // room for the decoded byte is checked here
                            if (room1) begin
                                s.esc = upc_pkg::ESC_HIGH;
                            end else begin
                                s.err = 1'b1;
                            end
                        end else if (unres && room1) begin
                            b[0] = in_byte;
                            nd   = 2'd1;
                        end else begin
                            s.err = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        prod_sum            = prod_ext + SW'(nd);
        bundle.data_cnt     = nd;
        bundle.has_end      = in_last;
        bundle.failed       = s.err || (s.esc != upc_pkg::ESC_NONE);
        bundle.count        = prod_sum[15:0];
        bundle.bytes        = b;
        has_result          = in_last || (nd != 2'd0);
        if (in_last) begin
            st_next.esc   = upc_pkg::ESC_NONE;
            st_next.hi    = 4'h0;
            st_next.err   = 1'b0;
            produced_next = '0;
        end else begin
            st_next       = s;
            produced_next = prod_sum[COUNT_WIDTH-1:0];
        end
    end

endmodule

### hdl/upc_out.sv
// Result register: holds the results of one word and hands them out in order.
// Depends on upc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module upc_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  upc_pkg::bundle_t  bundle,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_is_data,
    output logic              m_is_end,
    output logic              m_failed,
    output logic [15:0]       m_out_count,
    output logic              m_run_last
);
    logic             valid_reg, valid_next;
    logic [1:0]       idx_reg, idx_next;
    upc_pkg::bundle_t bnd_reg;
    logic [2:0]       total;
    logic [2:0]       idx_p1;
    logic             cur_data;
    logic             take;

    always_comb begin
        total    = {1'b0, bnd_reg.data_cnt} + {2'b00, bnd_reg.has_end};
        idx_p1   = {1'b0, idx_reg} + 3'd1;
        cur_data = idx_reg < bnd_reg.data_cnt;
        m_valid     = valid_reg;
        m_run_last  = idx_p1 == total;
        m_is_data   = cur_data;
        m_is_end    = !cur_data;
        m_out_byte  = cur_data ? bnd_reg.bytes[idx_reg] : 8'h00;
        m_failed    = cur_data ? 1'b0 : bnd_reg.failed;
        m_out_count = cur_data ? 16'h0000 : bnd_reg.count;
        take        = valid_reg && m_ready;
        free        = !valid_reg || (m_ready && m_run_last);
    end

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (take) begin
            if (m_run_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_p1[1:0];
            end
        end
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bnd_reg <= bundle;
        end
    end

    `ASSERT_IMPL(a_load_when_free, load, free, "result register overwritten")
    `ASSERT_IMPL(a_idx_in_range, valid_reg, idx_p1 <= total, "result index past end")
    `ASSERT_IMPL(a_end_is_last, valid_reg && m_is_end, m_run_last, "end result not final")
    `ASSERT_NEXT(a_hold_partial, take && !m_run_last && !load, valid_reg,
                 "word dropped mid sequence")

endmodule

### verif/tb_url_percent_codec_core.sv
// Self-checking testbench for url_percent_codec_core: directed table, then random strings,
// with every result checked against a predictor of the percent codec (chk rows: typed-in end result).
// Depends on upc_pkg and the RTL of url_percent_codec_core.
module tb_url_percent_codec_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic DIR_DECODE   = ~upc_pkg::DIR_ENCODE;
    localparam int   SETTLE_CYC   = 8;
    localparam int   TAIL_CYC     = 16;
    localparam int   STALL_LIMIT  = 1000;
    localparam int   RAND_WORDS   = 234;
    localparam int   CALM_AFTER   = 200;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_data;
        logic        is_end;
        logic        failed;
        logic [15:0] out_count;
        logic        run_last;
    } result_t;

    // One row of the directed part; chk rows carry the end result typed in.
    typedef struct packed {
        logic        dir;
        logic [15:0] cap;
        logic [7:0]  data;
        logic        last;
        logic        chk;
        logic        xfail;
        logic [15:0] xcount;
    } row_t;

    localparam row_t PLAN [26] = '{
        // encode at reset settings: plain byte, both byte extremes
        '{upc_pkg::DIR_ENCODE, 16'hFFFF, "A",   1'b0, 1'b0, 1'b0, 16'd0},
        '{upc_pkg::DIR_ENCODE, 16'hFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
        '{upc_pkg::DIR_ENCODE, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0, 16'd7},
        '{upc_pkg::DIR_ENCODE, 16'hFFFF, "~",   1'b1, 1'b1, 1'b0, 16'd1},
        // out of room on a plain byte
        '{upc_pkg::DIR_ENCODE, 16'd2,    "a",   1'b0, 1'b0, 1'b0, 16'd0},
        '{upc_pkg::DIR_ENCODE, 16'd2,    "b",   1'b0, 1'b0, 1'b0, 16'd0},
        '{upc_pkg::DIR_ENCODE, 16'd2,    "c",   1'b1, 1'b1, 1'b1, 16'd2},
        // escape that just fits, then no room at all
        '{upc_pkg::DIR_ENCODE, 16'd3,    " ",   1'b1, 1'b1, 1'b0, 16'd3},
        '{upc_pkg::DIR_ENCODE, 16'd0,    "z",   1'b1, 1'b1, 1'b1, 16'd0},
        // decode: escapes of both cases, then a plain byte
        '{DIR_DECODE, 16'hFFFF, upc_pkg::CHAR_PERCENT, 1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, "4",                   1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, "1",                   1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, upc_pkg::CHAR_PERCENT, 1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, "a",                   1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, "F",                   1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, "-",                   1'b1, 1'b1, 1'b0, 16'd3},
        // percent where a hex digit belongs
        '{DIR_DECODE, 16'hFFFF, upc_pkg::CHAR_PERCENT, 1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, upc_pkg::CHAR_PERCENT, 1'b1, 1'b1, 1'b1, 16'd0},
        // reserved byte, then the rest swallowed
        '{DIR_DECODE, 16'hFFFF, "/",                   1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, "Z",                   1'b1, 1'b1, 1'b1, 16'd0},
        // switch to encode inside an escape and back
        '{DIR_DECODE, 16'hFFFF, upc_pkg::CHAR_PERCENT, 1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, "4",                   1'b0, 1'b0, 1'b0, 16'd0},
        '{upc_pkg::DIR_ENCODE, 16'hFFFF, "x",          1'b0, 1'b0, 1'b0, 16'd0},
        '{DIR_DECODE, 16'hFFFF, "1",                   1'b1, 1'b1, 1'b0, 16'd2},
        // no room at the percent, then an escape left open at the end
        '{DIR_DECODE, 16'd0,    upc_pkg::CHAR_PERCENT, 1'b1, 1'b1, 1'b1, 16'd0},
        '{DIR_DECODE, 16'hFFFF, upc_pkg::CHAR_PERCENT, 1'b1, 1'b1, 1'b1, 16'd0}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        s_in_last = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_is_data;
    logic        m_is_end;
    logic        m_failed;
    logic [15:0] m_out_count;
    logic        m_run_last;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    // codec state as the predictor sees it
    logic          cur_dir    = upc_pkg::DIR_ENCODE;
    logic [15:0]   cur_cap    = 16'hFFFF;
    upc_pkg::esc_t esc_state  = upc_pkg::ESC_NONE;
    logic [3:0]    hi_nib     = 4'h0;
    logic [15:0]   bytes_made = 16'h0000;
    logic          str_failed = 1'b0;

    result_t     step_out [4];
    int          step_n;
    result_t     results_due [$];

    int          mismatches  = 0;
    int          words_sent  = 0;
    int          quiet_cyc   = 0;
    int          stall_left  = 0;
    bit          calm        = 1'b0;

    url_percent_codec_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_is_data   (m_is_data),
        .m_is_end    (m_is_end),
        .m_failed    (m_failed),
        .m_out_count (m_out_count),
        .m_run_last  (m_run_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic bit plain_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               c == "-" || c == "." || c == "_" || c == "~";
    endfunction

    // {is hex digit, value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'h00;
    endfunction

    function automatic logic [7:0] nib_char(input logic [3:0] n);
        return (n < 4'd10) ? "0" + 8'(n) : "A" + 8'(n - 4'd10);
    endfunction

    function automatic bit room_for(input int n);
        return int'(bytes_made) + n <= int'(cur_cap);
    endfunction

    function automatic logic [7:0] pick_plain();
        case ($urandom_range(0, 3))
            0: return "0" + 8'($urandom_range(0, 9));
            1: return "a" + 8'($urandom_range(0, 25));
            2: return "A" + 8'($urandom_range(0, 25));
            default: begin
                case ($urandom_range(0, 3))
                    0: return "-";
                    1: return ".";
                    2: return "_";
                    default: return "~";
                endcase
            end
        endcase
    endfunction

    task automatic push_data(input logic [7:0] b);
        step_out[step_n] = '{b, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0};
        step_n++;
    endtask

    // Works out the results of one accepted word into step_out.
    task automatic predict_codec_word(input logic [7:0] b, input logic last);
        logic [4:0] hx;
        hx = hex_nibble(b);
        step_n = 0;
        if (!str_failed) begin
            if (cur_dir == upc_pkg::DIR_ENCODE) begin
                if (plain_char(b)) begin
                    if (room_for(1)) begin
                        push_data(b);
                        bytes_made++;
                    end else begin
                        str_failed = 1'b1;
                    end
                end else if (room_for(3)) begin
                    push_data(upc_pkg::CHAR_PERCENT);
                    push_data(nib_char(b[7:4]));
                    push_data(nib_char(b[3:0]));
                    bytes_made += 16'd3;
                end else begin
                    str_failed = 1'b1;
                end
            end else if (esc_state != upc_pkg::ESC_NONE) begin
                if (!hx[4]) begin
                    str_failed = 1'b1;
                end else if (esc_state == upc_pkg::ESC_HIGH) begin
                    hi_nib    = hx[3:0];
                    esc_state = upc_pkg::ESC_LOW;
                end else begin
                    push_data({hi_nib, hx[3:0]});
                    bytes_made++;
                    esc_state = upc_pkg::ESC_NONE;
                end
            end else if (b == upc_pkg::CHAR_PERCENT) begin
                // room for the decoded byte is claimed at the percent
                if (room_for(1)) esc_state = upc_pkg::ESC_HIGH;
                else str_failed = 1'b1;
            end else if (plain_char(b) && room_for(1)) begin
                push_data(b);
                bytes_made++;
            end else begin
                str_failed = 1'b1;
            end
        end
        if (last) begin
            if (esc_state != upc_pkg::ESC_NONE) str_failed = 1'b1;
            step_out[step_n] = '{8'h00, 1'b0, 1'b1, str_failed, bytes_made, 1'b0};
            step_n++;
            esc_state  = upc_pkg::ESC_NONE;
            hi_nib     = 4'h0;
            bytes_made = 16'h0000;
            str_failed = 1'b0;
        end
        if (step_n > 0) step_out[step_n - 1].run_last = 1'b1;
    endtask

    task automatic note_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Holds the sender off until every expected result has come out.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        // a word may still be in flight without any result due
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == upc_pkg::REG_DIRECTION) cur_dir = val[0];
        else cur_cap = val;
    endtask

    task automatic send_word(input logic [7:0] b, input logic last, input logic chk,
                             input logic xfail, input logic [15:0] xcount);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        predict_codec_word(b, last);
        if (chk) begin
            step_out[step_n - 1].failed    = xfail;
            step_out[step_n - 1].out_count = xcount;
        end
        for (int i = 0; i < step_n; i++) results_due.push_back(step_out[i]);
        words_sent++;
    endtask

    // Result checker, ready pattern and watchdog.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    note_mismatch("result word with nothing expected");
                end else begin
                    want = results_due.pop_front();
                    if (m_out_byte !== want.out_byte)
                        note_mismatch($sformatf("out_byte %h, want %h",
                                                m_out_byte, want.out_byte));
                    if (m_is_data !== want.is_data)
                        note_mismatch($sformatf("is_data %b, want %b",
                                                m_is_data, want.is_data));
                    if (m_is_end !== want.is_end)
                        note_mismatch($sformatf("is_end %b, want %b",
                                                m_is_end, want.is_end));
                    if (m_failed !== want.failed)
                        note_mismatch($sformatf("failed %b, want %b",
                                                m_failed, want.failed));
                    if (m_out_count !== want.out_count)
                        note_mismatch($sformatf("out_count %0d, want %0d",
                                                m_out_count, want.out_count));
                    if (m_run_last !== want.run_last)
                        note_mismatch($sformatf("run_last %b, want %b",
                                                m_run_last, want.run_last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet_cyc = 0;
            else quiet_cyc++;
            if (quiet_cyc >= STALL_LIMIT) begin
                $display("FAIL url_percent_codec_core");
                $finish;
            end
        end
    end

    initial begin
        int          r;
        logic [15:0] cap_val;
        logic [7:0]  str_bytes [$];
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (PLAN[i]) begin
            if (PLAN[i].dir != cur_dir)
                write_reg(upc_pkg::REG_DIRECTION, {15'd0, PLAN[i].dir});
            if (PLAN[i].cap != cur_cap)
                write_reg(upc_pkg::REG_OUT_CAPACITY, PLAN[i].cap);
            send_word(PLAN[i].data, PLAN[i].last, PLAN[i].chk, PLAN[i].xfail, PLAN[i].xcount);
        end
        drain();
        words_sent = 0;

        while (words_sent < RAND_WORDS) begin
            if (words_sent >= CALM_AFTER) calm = 1'b1;
            case ($urandom_range(0, 9))
                6, 7:    cap_val = 16'($urandom_range(0, 12));
                8:       cap_val = 16'($urandom_range(0, 65535));
                9:       cap_val = 16'd0;
                default: cap_val = 16'hFFFF;
            endcase
            write_reg(upc_pkg::REG_DIRECTION, 16'($urandom_range(0, 1)));
            write_reg(upc_pkg::REG_OUT_CAPACITY, cap_val);
            repeat ($urandom_range(2, 5)) begin
                str_bytes.delete();
                repeat ($urandom_range(1, 8)) begin
                    r = $urandom_range(0, 19);
                    if (cur_dir == upc_pkg::DIR_ENCODE) begin
                        if (r < 10) str_bytes.push_back(pick_plain());
                        else str_bytes.push_back(8'($urandom_range(0, 255)));
                    end else if (r < 9) begin
                        str_bytes.push_back(pick_plain());
                    end else if (r == 17) begin
                        str_bytes.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        // full escape, one digit short, or a bare percent
                        str_bytes.push_back(upc_pkg::CHAR_PERCENT);
                        if (r != 19)
                            str_bytes.push_back(nib_char(4'($urandom_range(0, 15))) |
                                                ($urandom_range(0, 1) ? 8'h20 : 8'h00));
                        if (r < 17)
                            str_bytes.push_back(nib_char(4'($urandom_range(0, 15))) |
                                                ($urandom_range(0, 1) ? 8'h20 : 8'h00));
                    end
                end
                foreach (str_bytes[k]) begin
                    if (k != 0 && $urandom_range(0, 39) == 0)
                        write_reg(upc_pkg::REG_DIRECTION, {15'd0, ~cur_dir});
                    send_word(str_bytes[k], k == str_bytes.size() - 1, 1'b0, 1'b0, 16'd0);
                end
            end
        end

        drain();
        repeat (TAIL_CYC) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS url_percent_codec_core");
        end else begin
            $display("FAIL url_percent_codec_core");
        end
        $finish;
    end

endmodule
